### src/pole_pkg.sv
// ----------------------------------------------------------------------------
// pole_pkg
// Shared types and constants for the positional ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pole_pkg;

    localparam int POS_W          = 7;
    localparam int VAL_W          = 32;
    localparam int LEN_W          = 7;
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef struct packed {
        logic                    success;
        logic signed [VAL_W-1:0] read_value;
        logic [LEN_W-1:0]        length;
    } rsp_t;

endpackage

`default_nettype wire

### src/pole_req_if.sv
// ----------------------------------------------------------------------------
// pole_req_if
// Request channel: valid/ready handshake with mode, position and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface pole_req_if;

    logic                              valid;
    logic                              ready;
    pole_pkg::mode_t                   mode;
    logic [pole_pkg::POS_W-1:0]        position;
    logic signed [pole_pkg::VAL_W-1:0] value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);

endinterface

`default_nettype wire

### src/pole_rsp_if.sv
// ----------------------------------------------------------------------------
// pole_rsp_if
// Response channel: valid/ready handshake with success, read value, length.
// ----------------------------------------------------------------------------
`default_nettype none

interface pole_rsp_if;

    logic                              valid;
    logic                              ready;
    logic                              success;
    logic signed [pole_pkg::VAL_W-1:0] read_value;
    logic [pole_pkg::LEN_W-1:0]        length;

    modport source (output valid, output success, output read_value, output length, input ready);
    modport sink   (input valid, input success, input read_value, input length, output ready);

endinterface

`default_nettype wire

### src/pole_ram.sv
// ----------------------------------------------------------------------------
// pole_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/pole_seq.sv
// ----------------------------------------------------------------------------
// pole_seq
// Request sequencer: decodes a request, shifts entries through the RAM with a
// one-deep read/write-back pipeline, and produces the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pole_seq #(
    parameter int CAPACITY   = pole_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pole_pkg::DATA_WIDTH_DEF,
    localparam int AW        = $clog2(CAPACITY),
    localparam int CW        = $clog2(CAPACITY + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    pole_req_if.sink                   req,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output pole_pkg::rsp_t             res,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [DATA_WIDTH-1:0]      mem_wdata,
    output logic [AW-1:0]              mem_raddr,
    input  wire logic [DATA_WIDTH-1:0] mem_rdata
);

    localparam int CMPW = ((CW > pole_pkg::POS_W) ? CW : pole_pkg::POS_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_DRAIN = 5'b00100,
        S_PLACE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic                        wb_valid_reg, wb_valid_next;
    pole_pkg::mode_t             mode_reg, mode_next;
    logic                        dir_up_reg, dir_up_next;
    logic [AW-1:0]               rd_addr_reg, rd_addr_next;
    logic [AW-1:0]               wb_addr_reg, wb_addr_next;
    logic [AW-1:0]               place_addr_reg, place_addr_next;
    logic [CW-1:0]               remain_reg, remain_next;
    logic [DATA_WIDTH-1:0]       val_reg, val_next;
    logic                        ok_reg, ok_next;
    logic [pole_pkg::VAL_W-1:0]  rdv_reg, rdv_next;

    logic [CMPW-1:0]       pos_c;
    logic [CMPW-1:0]       cnt_c;
    logic                  not_full;
    logic                  pos_nz;
    logic                  in_list;
    logic                  ins_ok;
    logic [AW-1:0]         req_addr;
    logic [CW-1:0]         ins_moves;
    logic [CW-1:0]         del_moves;
    logic [DATA_WIDTH-1:0] store_val;

    // request decode
    assign pos_c     = CMPW'(req.position);
    assign cnt_c     = CMPW'(count_reg);
    assign not_full  = count_reg < CW'(CAPACITY);
    assign pos_nz    = req.position != '0;
    assign in_list   = pos_nz && (pos_c <= cnt_c);
    assign ins_ok    = not_full && pos_nz && (pos_c <= cnt_c + CMPW'(1));
    assign req_addr  = AW'(pos_c - CMPW'(1));
    assign ins_moves = CW'(cnt_c + CMPW'(1) - pos_c);
    assign del_moves = CW'(cnt_c - pos_c);
    assign store_val = DATA_WIDTH'(req.value);

    assign req.ready      = state_reg == S_IDLE;
    assign res_valid      = state_reg == S_DONE;
    assign res.success    = ok_reg;
    assign res.read_value = rdv_reg;
    assign res.length     = pole_pkg::LEN_W'(count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        wb_valid_next   = wb_valid_reg;
        mode_next       = mode_reg;
        dir_up_next     = dir_up_reg;
        rd_addr_next    = rd_addr_reg;
        wb_addr_next    = wb_addr_reg;
        place_addr_next = place_addr_reg;
        remain_next     = remain_reg;
        val_next        = val_reg;
        ok_next         = ok_reg;
        rdv_next        = rdv_reg;
        mem_we          = 1'b0;
        mem_waddr       = wb_addr_reg;
        mem_wdata       = mem_rdata;
        mem_raddr       = rd_addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next       = req.mode;
                    val_next        = store_val;
                    place_addr_next = req_addr;
                    ok_next         = 1'b0;
                    rdv_next        = '0;
                    wb_valid_next   = 1'b0;
                    state_next      = S_DONE;
                    unique case (req.mode)
                        pole_pkg::MODE_APPEND:
                        begin
                            if (not_full)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = store_val;
                                count_next = count_reg + CW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        pole_pkg::MODE_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                ok_next    = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (ins_moves == '0)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = req_addr;
                                    mem_wdata = store_val;
                                end
                                else
                                begin
                                    rd_addr_next = AW'(count_reg - CW'(1));
                                    remain_next  = ins_moves;
                                    dir_up_next  = 1'b0;
                                    state_next   = S_SHIFT;
                                end
                            end
                        end
                        pole_pkg::MODE_DELETE:
                        begin
                            if (in_list)
                            begin
                                ok_next    = 1'b1;
                                count_next = count_reg - CW'(1);
                                if (del_moves != '0)
                                begin
                                    rd_addr_next = AW'(pos_c);
                                    remain_next  = del_moves;
                                    dir_up_next  = 1'b1;
                                    state_next   = S_SHIFT;
                                end
                            end
                        end
                        pole_pkg::MODE_READ:
                        begin
                            if (in_list)
                            begin
                                ok_next    = 1'b1;
                                mem_raddr  = req_addr;
                                state_next = S_DRAIN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // read the next source while writing back the previous one
                mem_we        = wb_valid_reg;
                wb_valid_next = 1'b1;
                wb_addr_next  = dir_up_reg ? rd_addr_reg - AW'(1) : rd_addr_reg + AW'(1);
                rd_addr_next  = dir_up_reg ? rd_addr_reg + AW'(1) : rd_addr_reg - AW'(1);
                remain_next   = remain_reg - CW'(1);
                if (remain_reg == CW'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                mem_we        = wb_valid_reg;
                wb_valid_next = 1'b0;
                if (mode_reg == pole_pkg::MODE_READ)
                begin
                    rdv_next = pole_pkg::VAL_W'($signed(mem_rdata));
                end
                state_next = (mode_reg == pole_pkg::MODE_INSERT) ? S_PLACE : S_DONE;
            end
            S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = place_addr_reg;
                mem_wdata  = val_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            wb_valid_reg <= wb_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        dir_up_reg     <= dir_up_next;
        rd_addr_reg    <= rd_addr_next;
        wb_addr_reg    <= wb_addr_next;
        place_addr_reg <= place_addr_next;
        remain_reg     <= remain_next;
        val_reg        <= val_next;
        ok_reg         <= ok_next;
        rdv_reg        <= rdv_next;
    end

endmodule

`default_nettype wire

### src/pole_out.sv
// ----------------------------------------------------------------------------
// pole_out
// Output register stage for results, decoupling the sequencer from the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module pole_out (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            res_valid,
    output logic                 res_ready,
    input  wire pole_pkg::rsp_t  res,
    pole_rsp_if.source           rsp
);

    logic           valid_reg;
    pole_pkg::rsp_t data_reg;

    assign res_ready      = !valid_reg || rsp.ready;
    assign rsp.valid      = valid_reg;
    assign rsp.success    = data_reg.success;
    assign rsp.read_value = data_reg.read_value;
    assign rsp.length     = data_reg.length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

### src/positional_ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_engine_top
// Ordered list of signed values with append, positional insert, delete, read.
// ----------------------------------------------------------------------------
// The list lives in one RAM of CAPACITY entries, DATA_WIDTH bits each; the
// length is a register. Each request (mode, 1-based position, value) yields
// exactly one response (success, read_value, length after the request).
// Append, failed requests, and an insert or delete that moves no entry go
// from acceptance straight to S_DONE, where a response is offered; a read
// passes through S_DRAIN, an insert or delete that moves m > 0 entries
// through S_SHIFT and S_DRAIN, and such an insert then through S_PLACE; m
// is at most CAPACITY - 1. Shifting is paced by the single write port of
// the RAM: each moved entry costs one read and one write-back, each
// write-back overlapping the next read. One request is in progress at a
// time; a finished response sits in an output register so a new request can
// be taken while the previous response waits. Failed requests (out of
// range positions, insert or append into a full list) change nothing.
// Entries never written read back as whatever the RAM holds, but only
// positions inside the list are ever read. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_ordered_list_engine_top #(
    parameter int CAPACITY   = pole_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pole_pkg::DATA_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pole_req_if.sink   req,
    pole_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);

    // sequencer to output stage
    logic           res_valid;
    logic           res_ready;
    pole_pkg::rsp_t res;

    // RAM port
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    pole_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // element store
    pole_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pole_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
